[hdl/stq_pkg.sv]
package stq_pkg;

  localparam int unsigned IdBits   = 4;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned FuncBits = 2;
  localparam int unsigned KindBits = 2;

  localparam logic [FuncBits-1:0] FUNC_START = 2'd0;
  localparam logic [FuncBits-1:0] FUNC_STOP  = 2'd1;
  localparam logic [FuncBits-1:0] FUNC_TICK  = 2'd2;

  localparam logic [KindBits-1:0] KIND_ACK  = 2'd0;
  localparam logic [KindBits-1:0] KIND_FIRE = 2'd1;
  localparam logic [KindBits-1:0] KIND_NONE = 2'd2;

  typedef struct packed {
    logic [FuncBits-1:0] func;
    logic [IdBits-1:0]   timer_id;
    logic [TimeW-1:0]    start_time;
    logic [TimeW-1:0]    period;
    logic [TimeW-1:0]    now_time;
  } req_t;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [IdBits-1:0]   fired_id;
    logic                more_due;
    logic                last;
  } rsp_t;

endpackage

[hdl/sorted_timer_queue.sv]
// Sorted timer queue: timers kept in an expiry-ordered list of flip-flops.
// A start or stop searches the list, closes the gap and, for a start, walks back from the tail
// to insert; a tick gives one result per fired timer, or one none result if none is due.
// The list walks step one entry a cycle. One transaction at a time; busy is high meanwhile.
// Results appear one cycle each on rsp_valid_o; the receiver cannot stall.
// Reset (asynchronous, active low) empties the list; stores need no clearing.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned MAX_FIRES   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned SlotW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned LenW  = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned FireW = $clog2(MAX_FIRES + 1);
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_REMOVE, S_WRITE, S_INS, S_SHIFT, S_ACK,
    S_TCHK, S_TFIRE, S_TSUM, S_TINS_SET, S_EMIT
  } state_e;

  state_e state_q;
  logic [TimeW-1:0] exp_q [TIMER_SLOTS];
  logic [TimeW-1:0] per_q [TIMER_SLOTS];
  logic [SlotW-1:0] ord_q [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] lnk_q;
  logic [LenW-1:0] len_q;
  req_t req_q;
  logic [SlotW-1:0] slot_q;   // slot being handled
  logic [LenW-1:0]  ptr_q;    // walk pointer
  logic             tick_q;   // current unlink/insert belongs to a tick
  logic [SlotW-1:0] nxt_q;    // entry that followed the fired timer
  logic             hasnxt_q;
  logic [FireW-1:0] nfire_q;
  logic             more_q;
  logic             fin_q;    // last-result flag; only reset, never set or read
  logic [TimeW:0]   sum_q;

  // shared compare: list entry at ptr-1 later than slot's expiry
  logic [SlotW-1:0] prev_id;
  logic             cmp_gt;
  assign prev_id = ord_q[SlotW'(ptr_q - LenW'(1))];
  assign cmp_gt  = exp_q[prev_id] > exp_q[slot_q];

  logic [SlotW-1:0] head_id;
  logic             head_due;
  assign head_id  = hasnxt_q ? nxt_q : ord_q[0];
  assign head_due = exp_q[head_id] <= req_q.now_time;

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lnk_q       <= '0;
      len_q       <= '0;
      rsp_valid_o <= 1'b0;
      ptr_q       <= '0;
      tick_q      <= 1'b0;
      hasnxt_q    <= 1'b0;
      nfire_q     <= '0;
      more_q      <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      rsp_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q  <= req_i;
            slot_q <= SlotW'(req_i.timer_id);
            ptr_q  <= '0;
            tick_q <= 1'b0;
            if (req_i.func == FUNC_TICK) begin
              nfire_q  <= '0;
              more_q   <= 1'b0;
              hasnxt_q <= 1'b0;
              state_q  <= S_TCHK;
            end else if ((req_i.func == FUNC_START || req_i.func == FUNC_STOP) &&
                         (32'(req_i.timer_id) < TIMER_SLOTS)) begin
              state_q <= S_FIND;
            end else begin
              state_q <= S_ACK;
            end
          end
        end
        // search for the slot's position, one entry a cycle
        S_FIND: begin
          if (!lnk_q[slot_q]) begin
            state_q <= S_WRITE;
          end else if (ord_q[SlotW'(ptr_q)] == slot_q) begin
            state_q <= S_REMOVE;
          end else begin
            ptr_q <= ptr_q + LenW'(1);
          end
        end
        // close the gap
        S_REMOVE: begin
          if (ptr_q + LenW'(1) < len_q) begin
            ord_q[SlotW'(ptr_q)] <= ord_q[SlotW'(ptr_q + LenW'(1))];
            ptr_q <= ptr_q + LenW'(1);
          end else begin
            len_q         <= len_q - LenW'(1);
            lnk_q[slot_q] <= 1'b0;
            state_q       <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (tick_q) begin
            if (per_q[slot_q] != '0) state_q <= S_TSUM;
            else state_q <= S_EMIT;
          end else if (req_q.func == FUNC_START) begin
            exp_q[slot_q] <= req_q.start_time;
            per_q[slot_q] <= req_q.period;
            ptr_q         <= len_q;
            state_q       <= S_INS;
          end else begin
            state_q <= S_ACK;
          end
        end
        // walk back from the tail while the entry is later
        S_INS: begin
          if (ptr_q != '0 && cmp_gt) begin
            ord_q[SlotW'(ptr_q)] <= prev_id;
            ptr_q <= ptr_q - LenW'(1);
          end else begin
            ord_q[SlotW'(ptr_q)] <= slot_q;
            len_q         <= len_q + LenW'(1);
            lnk_q[slot_q] <= 1'b1;
            state_q       <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          state_q <= tick_q ? S_EMIT : S_ACK;
        end
        S_ACK: begin
          rsp_valid_o    <= 1'b1;
          rsp_o.kind     <= KIND_ACK;
          rsp_o.fired_id <= req_q.timer_id;
          rsp_o.more_due <= 1'b0;
          rsp_o.last     <= 1'b1;
          state_q        <= S_IDLE;
        end
        // tick: decide on the next entry
        S_TCHK: begin
          if ((!hasnxt_q && (nfire_q == '0) && len_q == '0) ||
              (nfire_q != '0 && !hasnxt_q) || !head_due) begin
            if (nfire_q == '0) begin
              rsp_valid_o    <= 1'b1;
              rsp_o.kind     <= KIND_NONE;
              rsp_o.fired_id <= req_q.timer_id;
              rsp_o.more_due <= 1'b0;
              rsp_o.last     <= 1'b1;
            end
            state_q <= S_IDLE;
          end else begin
            slot_q  <= head_id;
            ptr_q   <= '0;
            tick_q  <= 1'b1;
            state_q <= S_TFIRE;
          end
        end
        // find position of fired timer and its successor
        S_TFIRE: begin
          if (ord_q[SlotW'(ptr_q)] == slot_q) begin
            hasnxt_q <= (ptr_q + LenW'(1)) < len_q;
            nxt_q    <= ord_q[SlotW'(ptr_q + LenW'(1))];
            state_q  <= S_REMOVE;
          end else begin
            ptr_q <= ptr_q + LenW'(1);
          end
        end
        S_TSUM: begin
          sum_q   <= {1'b0, exp_q[slot_q]} + {1'b0, per_q[slot_q]};
          state_q <= S_TINS_SET;
        end
        S_TINS_SET: begin
          exp_q[slot_q] <= sum_q[TimeW] ? TimeMax : sum_q[TimeW-1:0];
          ptr_q         <= len_q;
          state_q       <= S_INS;
        end
        // report the fire; look ahead to decide last and more_due
        S_EMIT: begin
          rsp_valid_o    <= 1'b1;
          rsp_o.kind     <= KIND_FIRE;
          rsp_o.fired_id <= 4'(slot_q);
          nfire_q        <= nfire_q + FireW'(1);
          if (hasnxt_q && exp_q[nxt_q] <= req_q.now_time) begin
            if (nfire_q + FireW'(1) >= FireW'(MAX_FIRES)) begin
              rsp_o.more_due <= 1'b1;
              rsp_o.last     <= 1'b1;
              state_q        <= S_IDLE;
            end else begin
              rsp_o.more_due <= 1'b0;
              rsp_o.last     <= 1'b0;
              state_q        <= S_TCHK;
            end
          end else begin
            rsp_o.more_due <= 1'b0;
            rsp_o.last     <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // fire cap respected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfire_q <= FireW'(MAX_FIRES))
    else $error("fire count above cap");
  // list length bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= TIMER_SLOTS)
    else $error("list overflow");
  // a result ends the transaction when last is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |-> state_q == S_IDLE)
    else $error("last result but still busy");

endmodule
